>>> src/assert_macros.svh
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// trigger in one cycle implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

>>> src/svau_pkg.sv
// types and event codes shared by the scroll address unit stages
package svau_pkg;

    // event codes carried on the op field
    localparam logic [3:0] OP_CTRL   = 4'd0;
    localparam logic [3:0] OP_SCROLL = 4'd1;
    localparam logic [3:0] OP_ADDR   = 4'd2;
    localparam logic [3:0] OP_DATA   = 4'd3;
    localparam logic [3:0] OP_STATUS = 4'd4;
    localparam logic [3:0] OP_CX     = 4'd5;
    localparam logic [3:0] OP_FY     = 4'd6;
    localparam logic [3:0] OP_HCOPY  = 4'd7;
    localparam logic [3:0] OP_VCOPY  = 4'd8;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] value;
    } t_event;

    typedef struct packed {
        logic [14:0] current_address;
        logic [2:0]  fine_x_scroll;
        logic        toggle_state;
    } t_state_view;

endpackage

>>> src/scroll_vram_address_unit.sv
// top level of the scroll and video-memory address unit
// usage:
//   input channel (i_valid / o_ready) carries one event item: i_op selects a
//   control write, scroll write, address write, data-port access, status read,
//   coarse-x step, fine-y step, horizontal copy or vertical copy; i_value is
//   the processor byte for the register writes
//   output channel (o_valid / i_ready) returns one item per event with the
//   current address, tile and attribute fetch addresses, fine x, fine y and
//   the write toggle, all as they stand after that event
//   an accepted item is held in the input register, then passes through the
//   state update into the result register, which drives o_valid
//   throughput is one item per cycle while the receiver keeps i_ready high;
//   the state update is a single pass of short logic, so each event sees the
//   state left by the one before it
//   reset (i_rst_n low, synchronous) clears both addresses, fine x, the
//   toggle and the data-port step (step of one), and empties both registers
//   when the receiver holds i_ready low the result register keeps its item,
//   the input register fills, and o_ready falls until the result is taken
module scroll_vram_address_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_op,
    input  logic [7:0]  i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [14:0] o_current_address,
    output logic [13:0] o_tile_address,
    output logic [13:0] o_attribute_address,
    output logic [2:0]  o_fine_x_scroll,
    output logic [2:0]  o_fine_y_scroll,
    output logic        o_toggle_state
);
    import svau_pkg::*;

    `include "assert_macros.svh"

    t_event      in_event;
    t_event      stage_event;
    logic        stage_valid;
    logic        stage_ready;
    t_state_view next_view;
    logic        stage_fire;
    logic        fetch_match;

    assign in_event.op    = i_op;
    assign in_event.value = i_value;

    // input register
    svau_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_event (in_event),
        .o_valid (stage_valid),
        .i_ready (stage_ready),
        .o_event (stage_event)
    );

    // the state advances exactly when an event moves into the result register
    assign stage_fire = stage_valid && stage_ready;

    svau_update u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (stage_fire),
        .i_event (stage_event),
        .o_next  (next_view)
    );

    // result register
    svau_out_stage u_out (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (stage_valid),
        .o_ready             (stage_ready),
        .i_view              (next_view),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_current_address   (o_current_address),
        .o_tile_address      (o_tile_address),
        .o_attribute_address (o_attribute_address),
        .o_fine_x_scroll     (o_fine_x_scroll),
        .o_fine_y_scroll     (o_fine_y_scroll),
        .o_toggle_state      (o_toggle_state)
    );

    // fetch addresses agree with the reported current address
    assign fetch_match = (o_tile_address[11:0] == o_current_address[11:0]) &&
                         (o_attribute_address[11:10] == o_current_address[11:10]);

    // an accepted item is in the input register on the next cycle
    `ASSERT_NEXT(a_in_lands, i_clk, i_rst_n, i_valid && o_ready, stage_valid)
    // an event leaving the input register always produces a result
    `ASSERT_NEXT(a_out_lands, i_clk, i_rst_n, stage_fire, o_valid)
    // a valid result carries consistent fetch addresses
    `ASSERT_ALWAYS(a_tile_match, i_clk, i_rst_n, !o_valid || fetch_match)
endmodule

>>> src/svau_in_stage.sv
// input register for incoming event items
module svau_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  svau_pkg::t_event i_event,
    output logic            o_valid,
    input  logic            i_ready,
    output svau_pkg::t_event o_event
);
    import svau_pkg::*;

    logic   r_valid;
    t_event r_event;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_event = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_event <= i_event;
        end
    end
endmodule

>>> src/svau_update.sv
// scroll state registers and their per-event update
module svau_update (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  svau_pkg::t_event      i_event,
    output svau_pkg::t_state_view o_next
);
    import svau_pkg::*;

    logic [14:0] r_cur, n_cur;
    logic [14:0] r_temp, n_temp;
    logic [2:0]  r_fine_x, n_fine_x;
    logic        r_toggle, n_toggle;
    logic        r_step32, n_step32;
    logic [7:0]  v;

    assign v = i_event.value;

    always_comb begin
        n_cur    = r_cur;
        n_temp   = r_temp;
        n_fine_x = r_fine_x;
        n_toggle = r_toggle;
        n_step32 = r_step32;
        case (i_event.op)
            OP_CTRL: begin
                n_temp[11:10] = v[1:0];
                n_step32      = v[2];
            end
            OP_SCROLL: begin
                if (!r_toggle) begin
                    n_temp[4:0] = v[7:3];
                    n_fine_x    = v[2:0];
                    n_toggle    = 1'b1;
                end else begin
                    n_temp[9:5]   = v[7:3];
                    n_temp[14:12] = v[2:0];
                    n_toggle      = 1'b0;
                end
            end
            OP_ADDR: begin
                if (!r_toggle) begin
                    n_temp[13:8] = v[5:0];
                    n_temp[14]   = 1'b0;
                    n_toggle     = 1'b1;
                end else begin
                    n_temp[7:0] = v;
                    n_cur       = {r_temp[14:8], v};
                    n_toggle    = 1'b0;
                end
            end
            OP_DATA: begin
                n_cur = r_cur + (r_step32 ? 15'd32 : 15'd1);
            end
            OP_STATUS: begin
                n_toggle = 1'b0;
            end
            OP_CX: begin
                if (r_cur[4:0] == 5'd31) begin
                    n_cur[4:0] = 5'd0;
                    n_cur[10]  = ~r_cur[10];
                end else begin
                    n_cur[4:0] = r_cur[4:0] + 5'd1;
                end
            end
            OP_FY: begin
                if (r_cur[14:12] != 3'd7) begin
                    n_cur[14:12] = r_cur[14:12] + 3'd1;
                end else begin
                    n_cur[14:12] = 3'd0;
                    if (r_cur[9:5] == 5'd29) begin
                        n_cur[9:5] = 5'd0;
                        n_cur[11]  = ~r_cur[11];
                    end else if (r_cur[9:5] == 5'd31) begin
                        n_cur[9:5] = 5'd0;
                    end else begin
                        n_cur[9:5] = r_cur[9:5] + 5'd1;
                    end
                end
            end
            OP_HCOPY: begin
                n_cur[4:0] = r_temp[4:0];
                n_cur[10]  = r_temp[10];
            end
            OP_VCOPY: begin
                n_cur[9:5]   = r_temp[9:5];
                n_cur[14:11] = r_temp[14:11];
            end
            default: begin
                n_cur = r_cur;
            end
        endcase
    end

    assign o_next.current_address = n_cur;
    assign o_next.fine_x_scroll   = n_fine_x;
    assign o_next.toggle_state    = n_toggle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_temp   <= '0;
            r_fine_x <= '0;
            r_toggle <= 1'b0;
            r_step32 <= 1'b0;
        end else if (i_fire) begin
            r_cur    <= n_cur;
            r_temp   <= n_temp;
            r_fine_x <= n_fine_x;
            r_toggle <= n_toggle;
            r_step32 <= n_step32;
        end
    end
endmodule

>>> src/svau_out_stage.sv
// result register with tile and attribute fetch address forming
module svau_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  svau_pkg::t_state_view i_view,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [14:0]           o_current_address,
    output logic [13:0]           o_tile_address,
    output logic [13:0]           o_attribute_address,
    output logic [2:0]            o_fine_x_scroll,
    output logic [2:0]            o_fine_y_scroll,
    output logic                  o_toggle_state
);
    import svau_pkg::*;

    logic        r_valid;
    logic [14:0] r_cur;
    logic [13:0] r_tile;
    logic [13:0] r_attr;
    logic [2:0]  r_fine_x;
    logic        r_toggle;
    logic [14:0] a;

    assign a       = i_view.current_address;
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // nametable base 0x2000, attribute table at 0x23c0 of the selected nametable
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cur    <= a;
            r_tile   <= {2'b10, a[11:0]};
            r_attr   <= {2'b10, a[11:10], 4'b1111, a[9:7], a[4:2]};
            r_fine_x <= i_view.fine_x_scroll;
            r_toggle <= i_view.toggle_state;
        end
    end

    assign o_valid             = r_valid;
    assign o_current_address   = r_cur;
    assign o_tile_address      = r_tile;
    assign o_attribute_address = r_attr;
    assign o_fine_x_scroll     = r_fine_x;
    assign o_fine_y_scroll     = r_cur[14:12];
    assign o_toggle_state      = r_toggle;
endmodule

>>> sim/tb_scroll_vram_address_unit.sv
// self-checking testbench for the scroll and video-memory address unit
module tb_scroll_vram_address_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import svau_pkg::*;

    // spare event codes on i_op; they leave the state alone
    localparam logic [3:0] OP_SPARE_FIRST = 4'd9;
    localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

    // one item as it leaves the block
    typedef struct packed {
        logic [14:0] vaddr;
        logic [13:0] tile;
        logic [13:0] attr;
        logic [2:0]  fine_x;
        logic [2:0]  fine_y;
        logic        toggle;
    } t_scroll_view;

    // one item waiting to be sent; hold makes the sender wait for a full drain
    typedef struct {
        t_event ev;
        bit     hold;
    } t_queued_event;

    localparam int unsigned HALF_PERIOD    = 10;
    localparam int unsigned RESET_CYCLES   = 5;
    localparam int unsigned RANDOM_EVENTS  = 1550;
    localparam int unsigned SETTLE_CYCLES  = 8;     // margin after the last result
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
    localparam int unsigned REPORT_LIMIT   = 40;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [3:0]  i_op    = OP_CTRL;
    logic [7:0]  i_value = 8'h00;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [14:0] o_current_address;
    logic [13:0] o_tile_address;
    logic [13:0] o_attribute_address;
    logic [2:0]  o_fine_x_scroll;
    logic [2:0]  o_fine_y_scroll;
    logic        o_toggle_state;

    scroll_vram_address_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_op                (i_op),
        .i_value             (i_value),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_current_address   (o_current_address),
        .o_tile_address      (o_tile_address),
        .o_attribute_address (o_attribute_address),
        .o_fine_x_scroll     (o_fine_x_scroll),
        .o_fine_y_scroll     (o_fine_y_scroll),
        .o_toggle_state      (o_toggle_state)
    );

    // predictor state: the testbench's own copy of the loopy registers
    logic [14:0] cur_vaddr   = '0;
    logic [14:0] tmp_vaddr   = '0;
    logic [2:0]  fine_x      = '0;
    logic        write_phase = 1'b0;   // high between first and second write
    logic        step_32     = 1'b0;   // data-port increment of 32 across

    t_queued_event event_backlog[$];   // items not yet offered to the block
    t_scroll_view  pending_views[$];   // expected results, oldest first

    bit          hold_next;            // next pushed item waits for a full drain
    int unsigned counted_events;       // items that touch the state
    int unsigned op_hits[16];
    int unsigned views_checked;
    int unsigned failures;
    int unsigned quiet_cycles;
    int unsigned tx_gap_left, tx_burst_left;
    int unsigned rx_stall_left, rx_burst_left;
    logic        ev_taken = 1'b0;      // input handshake at the last rising edge

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // apply one event to the predicted state
    task automatic apply_vram_event(input logic [3:0] op, input logic [7:0] value);
        logic [4:0] cy;
        cy = cur_vaddr[9:5];
        case (op)
            OP_CTRL: begin
                tmp_vaddr[11:10] = value[1:0];
                step_32          = value[2];
            end
            OP_SCROLL: begin
                if (!write_phase) begin
                    // first write: coarse x and fine x
                    tmp_vaddr[4:0] = value[7:3];
                    fine_x         = value[2:0];
                    write_phase    = 1'b1;
                end else begin
                    // second write: coarse y and fine y
                    tmp_vaddr[9:5]   = value[7:3];
                    tmp_vaddr[14:12] = value[2:0];
                    write_phase      = 1'b0;
                end
            end
            OP_ADDR: begin
                if (!write_phase) begin
                    // high byte: only six bits land, bit 14 is cleared
                    tmp_vaddr[13:8] = value[5:0];
                    tmp_vaddr[14]   = 1'b0;
                    write_phase     = 1'b1;
                end else begin
                    tmp_vaddr[7:0] = value;
                    cur_vaddr      = tmp_vaddr;
                    write_phase    = 1'b0;
                end
            end
            OP_DATA: cur_vaddr = cur_vaddr + (step_32 ? 15'd32 : 15'd1);
            OP_STATUS: write_phase = 1'b0;
            OP_CX: begin
                if (cur_vaddr[4:0] == 5'd31) begin
                    cur_vaddr[4:0] = 5'd0;
                    cur_vaddr[10]  = ~cur_vaddr[10];
                end else begin
                    cur_vaddr[4:0] = cur_vaddr[4:0] + 5'd1;
                end
            end
            OP_FY: begin
                if (cur_vaddr[14:12] != 3'd7) begin
                    cur_vaddr[14:12] = cur_vaddr[14:12] + 3'd1;
                end else begin
                    cur_vaddr[14:12] = 3'd0;
                    // row 29 is the last visible row, rows 30 and 31 hold attributes
                    if (cy == 5'd29) begin
                        cy            = 5'd0;
                        cur_vaddr[11] = ~cur_vaddr[11];
                    end else if (cy == 5'd31) begin
                        cy = 5'd0;
                    end else begin
                        cy = cy + 5'd1;
                    end
                    cur_vaddr[9:5] = cy;
                end
            end
            OP_HCOPY: begin
                cur_vaddr[4:0] = tmp_vaddr[4:0];
                cur_vaddr[10]  = tmp_vaddr[10];
            end
            OP_VCOPY: begin
                cur_vaddr[9:5]   = tmp_vaddr[9:5];
                cur_vaddr[14:11] = tmp_vaddr[14:11];
            end
            default: ;
        endcase
    endtask

    // what the block should report for the predicted state
    function automatic t_scroll_view fetch_view();
        t_scroll_view view;
        view.vaddr  = cur_vaddr;
        view.tile   = {2'b10, cur_vaddr[11:0]};
        view.attr   = {2'b10, cur_vaddr[11:10], 4'b1111, cur_vaddr[9:7], cur_vaddr[4:2]};
        view.fine_x = fine_x;
        view.fine_y = cur_vaddr[14:12];
        view.toggle = write_phase;
        return view;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic push_event(input logic [3:0] op, input logic [7:0] value);
        t_queued_event item;
        item.ev.op    = op;
        item.ev.value = value;
        item.hold     = hold_next;
        hold_next     = 1'b0;
        event_backlog.push_back(item);
        if (op <= OP_VCOPY)
            counted_events++;
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // edge cases first: coarse x, fine y and coarse y wraps, toggle handling, spare codes
    task automatic build_directed();
        push_event(OP_CTRL,   8'hFF);  // nametable 3, step of 32
        push_event(OP_SCROLL, 8'hFF);  // coarse x 31, fine x 7
        push_event(OP_SCROLL, 8'hFF);  // coarse y 31, fine y 7
        push_event(OP_HCOPY,  8'h00);
        push_event(OP_VCOPY,  8'h00);  // current address all ones
        push_event(OP_FY,     8'hFF);  // row 31 wraps without a flip
        push_event(OP_DATA,   8'h00);  // step of 32
        push_event(OP_SCROLL, 8'h00);
        push_event(OP_SCROLL, 8'hEF);  // row 29, fine y 7
        push_event(OP_VCOPY,  8'h00);
        push_event(OP_FY,     8'h00);  // row 29 wraps and flips the vertical table
        push_event(OP_SCROLL, 8'hF8);  // first write again, coarse x 31
        push_event(OP_STATUS, 8'hFF);  // clears the toggle
        push_event(OP_HCOPY,  8'h00);
        push_event(OP_CX,     8'hFF);  // column 31 wraps and flips
        push_event(OP_ADDR,   8'hFF);  // bits 6 and 7 dropped, bit 14 cleared
        push_event(OP_ADDR,   8'hFF);
        push_event(OP_DATA,   8'hFF);
        push_event(OP_CTRL,   8'h00);  // back to a step of one
        push_event(OP_ADDR,   8'h00);
        push_event(OP_ADDR,   8'h00);
        push_event(OP_DATA,   8'h00);
        push_event(OP_SPARE_FIRST, 8'hFF);
        push_event(OP_SPARE_LAST,  8'hAA);
    endtask

    // mostly frame-shaped traffic: register setup mixed with rendering runs
    task automatic build_random_traffic();
        int unsigned kind, run_len, k, target;
        target    = counted_events + RANDOM_EVENTS;
        hold_next = 1'b1;
        while (counted_events < target) begin
            kind = $urandom_range(0, 19);
            if ($urandom_range(0, 99) == 0)
                hold_next = 1'b1;
            if (kind < 4) begin
                // scroll pair, sometimes cut short
                if ($urandom_range(0, 1))
                    push_event(OP_STATUS, rand_byte());
                push_event(OP_SCROLL, rand_byte());
                if ($urandom_range(0, 99) >= 15)
                    push_event(OP_SCROLL, rand_byte());
            end else if (kind < 7) begin
                // address pair followed by data-port traffic
                if ($urandom_range(0, 1))
                    push_event(OP_STATUS, rand_byte());
                push_event(OP_ADDR, rand_byte());
                if ($urandom_range(0, 99) >= 15)
                    push_event(OP_ADDR, rand_byte());
                run_len = $urandom_range(0, 6);
                for (k = 0; k < run_len; k++)
                    push_event(OP_DATA, rand_byte());
            end else if (kind == 7) begin
                push_event(OP_CTRL, rand_byte());
            end else if (kind < 15) begin
                // rendering run across tiles and rows
                if ($urandom_range(0, 1))
                    push_event(OP_VCOPY, rand_byte());
                if ($urandom_range(0, 1))
                    push_event(OP_HCOPY, rand_byte());
                run_len = $urandom_range(1, 48);
                for (k = 0; k < run_len; k++) begin
                    if ($urandom_range(0, 3) == 0)
                        push_event(OP_FY, rand_byte());
                    else if ($urandom_range(0, 31) == 0)
                        push_event(OP_HCOPY, rand_byte());
                    else
                        push_event(OP_CX, rand_byte());
                end
            end else if (kind < 17) begin
                // end of a scanline
                push_event(OP_FY, rand_byte());
                push_event(OP_HCOPY, rand_byte());
            end else if (kind < 19) begin
                run_len = $urandom_range(1, 10);
                for (k = 0; k < run_len; k++)
                    push_event(OP_DATA, rand_byte());
            end else begin
                // noise over the whole code space, spare codes included
                run_len = $urandom_range(1, 6);
                for (k = 0; k < run_len; k++)
                    push_event(4'($urandom_range(0, 15)), rand_byte());
            end
        end
    endtask

    // gap length for either side: mostly none or short, a few long, and
    // now and then a burst with no idling at all
    function automatic int unsigned next_gap(inout int unsigned burst_left);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        if (roll == 0) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // driver: offers items at the falling edge, holds each until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : feed
        t_queued_event next_item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || ev_taken) begin
            if (tx_gap_left != 0) begin
                tx_gap_left--;
                i_valid <= 1'b0;
            end else if (event_backlog.size() != 0 &&
                         !(event_backlog[0].hold && pending_views.size() != 0)) begin
                next_item = event_backlog.pop_front();
                i_valid   <= 1'b1;
                i_op      <= next_item.ev.op;
                i_value   <= next_item.ev.value;
                tx_gap_left = next_gap(tx_burst_left);
            end else begin
                // out of items, or waiting for every result to come back
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls on i_ready, independent of o_valid
    always @(negedge i_clk) begin : sink
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            i_ready <= 1'b0;
            rx_stall_left--;
        end else begin
            i_ready <= 1'b1;
            rx_stall_left = next_gap(rx_burst_left);
        end
    end

    // ------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_scroll_view want;
        if (!i_rst_n) begin
            ev_taken <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_views.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("%0t ns: result with nothing expected, actual address 0x%0h",
                                 $time, o_current_address);
                end else begin
                    want = pending_views.pop_front();
                    check_field("current_address",   want.vaddr,  o_current_address);
                    check_field("tile_address",      want.tile,   o_tile_address);
                    check_field("attribute_address", want.attr,   o_attribute_address);
                    check_field("fine_x_scroll",     want.fine_x, o_fine_x_scroll);
                    check_field("fine_y_scroll",     want.fine_y, o_fine_y_scroll);
                    check_field("toggle_state",      want.toggle, o_toggle_state);
                    views_checked++;
                end
            end
            if (i_valid && o_ready) begin
                apply_vram_event(i_op, i_value);
                pending_views.push_back(fetch_view());
                op_hits[i_op]++;
            end
            ev_taken <= i_valid && o_ready;
            if ((o_valid && i_ready) || (i_valid && o_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // a hung handshake ends the run
    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_views.size());
        $display("scroll_vram_address_unit regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial begin : run
        int unsigned spare;
        build_directed();
        build_random_traffic();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every item taken, then every result back, then a short settle
        while (event_backlog.size() != 0 || i_valid)
            @(negedge i_clk);
        while (pending_views.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        spare = 0;
        for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
            spare += op_hits[k];
        $display("covered: %0d ctrl, %0d scroll, %0d addr, %0d data, %0d status, %0d spare",
                 op_hits[OP_CTRL], op_hits[OP_SCROLL], op_hits[OP_ADDR],
                 op_hits[OP_DATA], op_hits[OP_STATUS], spare);
        $display("covered: %0d coarse-x, %0d fine-y, %0d copies; %0d results, %0d errors",
                 op_hits[OP_CX], op_hits[OP_FY],
                 op_hits[OP_HCOPY] + op_hits[OP_VCOPY], views_checked, failures);
        if (failures == 0)
            $display("scroll_vram_address_unit regression: pass");
        else
            $display("scroll_vram_address_unit regression: fail");
        $finish;
    end

endmodule
